// ----- rtl/pbfu_pkg.sv -----
`timescale 1ns / 1ps

package pbfu_pkg;

    localparam int WORD_BITS      = 32;
    localparam int MAX_FIELD_BITS = 32;
    // count width: holds 0..WORD_BITS
    localparam int CNT_BITS       = $clog2(WORD_BITS + 1);
    // accumulator: leftover bits (at most WORD_BITS-1) followed by one word
    localparam int ACC_BITS       = 2 * WORD_BITS - 1;
    localparam int TOTAL_BITS     = $clog2(ACC_BITS + 1);

    localparam logic [CNT_BITS-1:0] BPP_RESET   = CNT_BITS'(16);
    localparam logic [CNT_BITS-1:0] WIDTH_MAX   = CNT_BITS'(MAX_FIELD_BITS);
    localparam logic [CNT_BITS-1:0] WORD_COUNT  = CNT_BITS'(WORD_BITS);

    localparam logic MODE_DATA   = 1'b0;
    localparam logic MODE_BITMAP = 1'b1;
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_FLAG   = 1'b1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic more;
        logic last_next;
    } t_dp_status;

endpackage

// ----- rtl/pbfu_ifs.sv -----
`timescale 1ns / 1ps

interface pbfu_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] word;
    logic [5:0]  bitmap_bits_used;

    modport source (output valid, mode, word, bitmap_bits_used, input ready);
    modport sink   (input valid, mode, word, bitmap_bits_used, output ready);
endinterface

interface pbfu_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic        kind;
    logic        last;

    modport source (output valid, value, kind, last, input ready);
    modport sink   (input valid, value, kind, last, output ready);
endinterface

// ----- rtl/pbfu_datapath.sv -----
`timescale 1ns / 1ps

module pbfu_datapath
    import pbfu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    input  logic                 i_cfg_wr_en,
    input  logic [CNT_BITS-1:0]  i_cfg_wr_data,
    input  logic                 i_mode,
    input  logic [WORD_BITS-1:0] i_word,
    input  logic [CNT_BITS-1:0]  i_bitmap_bits_used,
    output logic [WORD_BITS-1:0] o_value,
    output logic                 o_kind,
    output logic                 o_last
);

    logic [CNT_BITS-1:0]   r_bpp,   n_bpp;
    logic [ACC_BITS-1:0]   r_acc,   n_acc;
    logic [TOTAL_BITS-1:0] r_total, n_total;
    logic                  r_kind,  n_kind;
    logic [CNT_BITS-1:0]   r_cnt,   n_cnt;
    logic [WORD_BITS-1:0]  r_value, n_value;
    logic                  r_okind, n_okind;
    logic                  r_olast, n_olast;

    logic [CNT_BITS-1:0]   w_data;
    logic [CNT_BITS-1:0]   w_eff;
    logic [TOTAL_BITS-1:0] shift;
    logic [ACC_BITS-1:0]   shifted;
    logic [WORD_BITS-1:0]  fmask;
    logic [WORD_BITS-1:0]  field;
    logic [WORD_BITS-1:0]  value;
    logic [CNT_BITS-1:0]   used_clip;

    always_comb begin
        if (r_bpp == '0) begin
            w_data = CNT_BITS'(1);
        end else if (r_bpp > WIDTH_MAX) begin
            w_data = WIDTH_MAX;
        end else begin
            w_data = r_bpp;
        end
        w_eff     = r_kind ? CNT_BITS'(1) : w_data;
        shift     = r_total - TOTAL_BITS'(w_eff);
        shifted   = r_acc >> shift;
        fmask     = {WORD_BITS{1'b1}} >> (WORD_COUNT - w_eff);
        field     = shifted[WORD_BITS-1:0] & fmask;
        value     = r_kind ? {{(WORD_BITS-1){1'b0}}, ~field[0]} : field;
        used_clip = (i_bitmap_bits_used > WORD_COUNT) ? WORD_COUNT : i_bitmap_bits_used;

        o_status.more      = r_kind ? (r_cnt != '0) : (r_total >= TOTAL_BITS'(w_data));
        o_status.last_next = r_kind ? (r_cnt == CNT_BITS'(1)) : (shift < TOTAL_BITS'(w_data));
    end

    always_comb begin
        n_bpp   = r_bpp;
        n_acc   = r_acc;
        n_total = r_total;
        n_kind  = r_kind;
        n_cnt   = r_cnt;
        n_value = r_value;
        n_okind = r_okind;
        n_olast = r_olast;

        if (i_cfg_wr_en) begin
            // a width change drops any leftover bits
            n_bpp   = i_cfg_wr_data;
            n_total = '0;
        end

        if (i_cmd.load) begin
            if (i_mode == MODE_BITMAP) begin
                n_acc   = {{(ACC_BITS-WORD_BITS){1'b0}}, i_word};
                n_total = TOTAL_BITS'(WORD_BITS);
                n_kind  = KIND_FLAG;
                n_cnt   = used_clip;
            end else begin
                // append the word below the leftover bits
                n_acc   = {r_acc[ACC_BITS-WORD_BITS-1:0], i_word};
                n_total = r_total + TOTAL_BITS'(WORD_BITS);
                n_kind  = KIND_DATA;
                n_cnt   = '0;
            end
        end

        if (i_cmd.step) begin
            n_value = value;
            n_okind = r_kind;
            n_olast = o_status.last_next;
            n_total = shift;
            n_cnt   = r_cnt - CNT_BITS'(1);
        end

        // a bitmap word leaves no data bits behind
        if (i_cmd.finish && r_kind) begin
            n_total = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp   <= BPP_RESET;
            r_total <= '0;
            r_kind  <= KIND_DATA;
            r_cnt   <= '0;
        end else begin
            r_bpp   <= n_bpp;
            r_total <= n_total;
            r_kind  <= n_kind;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_value <= n_value;
        r_okind <= n_okind;
        r_olast <= n_olast;
    end

    assign o_value = r_value;
    assign o_kind  = r_okind;
    assign o_last  = r_olast;

endmodule

// ----- rtl/pbfu_ctrl.sv -----
`timescale 1ns / 1ps

module pbfu_ctrl
    import pbfu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   can_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        can_emit    = !r_out_valid || i_out_ready;

        case (r_state)
            ST_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!i_status.more) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end else if (can_emit) begin
                    o_cmd.step  = 1'b1;
                    n_out_valid = 1'b1;
                    if (i_status.last_next) begin
                        o_cmd.finish = 1'b1;
                        n_state      = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/packed_bit_field_unpacker.sv -----
`timescale 1ns / 1ps
// Flow: a taken word is loaded into the accumulator; each result is extracted and registered.
// Throughput: one result per cycle from a shared field extractor while the output is not
// stalled; the next word is taken only after every result of the current word is extracted.
// Output stalls hold the extractor; the next word is taken while the last result waits.
// Reset (synchronous, active low): no leftover bits, field width 16, output empty.

module packed_bit_field_unpacker
    import pbfu_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    pbfu_in_if.sink             i_in,
    pbfu_out_if.source          o_out,
    input  logic                i_cfg_wr_en,
    input  logic [CNT_BITS-1:0] i_cfg_wr_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    pbfu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    pbfu_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_mode             (i_in.mode),
        .i_word             (i_in.word),
        .i_bitmap_bits_used (i_in.bitmap_bits_used),
        .o_value            (o_out.value),
        .o_kind             (o_out.kind),
        .o_last             (o_out.last)
    );

endmodule

// ----- rtl/pbfu_checker.sv -----
`timescale 1ns / 1ps

module pbfu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_value,
    input logic        i_out_kind,
    input logic        i_out_last
);

    // one word at a time: busy right after taking one
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input taken while previous word still in work");

    // more results of the current word pending: no new word
    a_no_accept_mid_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_last) |-> !i_in_ready)
        else $error("input ready before last result of word");

    a_flag_is_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_kind) |-> (i_out_value[31:1] == 31'd0))
        else $error("bitmap flag wider than one bit");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("output item dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind packed_bit_field_unpacker pbfu_checker u_pbfu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_value (o_out.value),
    .i_out_kind  (o_out.kind),
    .i_out_last  (o_out.last)
);
